>>> hw/rtl/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants of the seven-segment scan shifter
// Holds the store geometry, operation and register codes, the segment code
// table and the status bundle of the decimal converter.
// ----------------------------------------------------------------------------
package sss_pkg;

    // Store geometry: groups of four digits, one segment byte per digit.
    localparam int GROUP_COUNT      = 8;
    localparam int DIGITS_PER_GROUP = 4;
    localparam int SEG_W            = 8;
    localparam int ROW_W            = DIGITS_PER_GROUP * SEG_W;
    localparam int GRP_W            = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int DIG_W            = 2;
    localparam int BIT_W            = 3;

    // Field widths of a transaction.
    localparam int OP_W    = 2;
    localparam int GROUP_W = 3;
    localparam int VALUE_W = 16;

    // Converter: five BCD digits cover a 16-bit value.
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int BCNT_W     = $clog2(VALUE_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLTAGE_LED_GROUP = 1'b0,
        CFG_BATTERY_LED_GROUP = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] VOLTAGE_LED_RESET = 3'd6;
    localparam logic [CFG_DATA_W-1:0] BATTERY_LED_RESET = 3'd7;

    typedef enum logic [OP_W-1:0] {
        OP_NUMBER = 2'd0,
        OP_LED    = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Status handed from the decimal converter to the control logic.
    typedef struct packed {
        logic                                 done;
        logic [DIGITS_PER_GROUP-1:0][3:0]     digits;
    } t_bcd_status;

    // Common-anode segment code of one decimal digit.
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'hc0;
            4'd1:    code = 8'hf9;
            4'd2:    code = 8'ha4;
            4'd3:    code = 8'hb0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hf8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hff;
        endcase
        return code;
    endfunction

endpackage

>>> hw/rtl/sss_bcd.sv
// ----------------------------------------------------------------------------
// sss_bcd: bit-serial binary to decimal converter
// Shift-and-add-three conversion of a 16-bit value, one bit per cycle. The
// lowest four decimal digits (the value modulo 10000) are reported.
// ----------------------------------------------------------------------------
module sss_bcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sss_pkg::VALUE_W-1:0]   i_value,
    output sss_pkg::t_bcd_status          o_status
);
    import sss_pkg::*;

    logic                r_run;
    logic [BCNT_W-1:0]   r_cnt;
    logic                r_done;
    logic [VALUE_W-1:0]  r_bin;
    logic [BCD_W-1:0]    r_bcd;
    logic [BCD_W-1:0]    n_adj;

    // Add three to every digit of five or more before the next shift.
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            n_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                        : r_bcd[i*4 +: 4];
        end
    end

    // Control: run until every input bit is shifted in, then pulse done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == BCNT_W'(VALUE_W - 1));
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == BCNT_W'(VALUE_W - 1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // Datapath: the binary word shifts out MSB first into the decimal word.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_run) begin
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bcd <= {n_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
        end
    end

    assign o_status.done   = r_done;
    assign o_status.digits = r_bcd[DIGITS_PER_GROUP*4-1:0];

endmodule

>>> hw/rtl/seven_segment_scan_shifter.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_shifter: multiplexed seven-segment display driver
// Keeps the segment bytes of eight four-digit groups and, on each refresh
// tick, shifts the current scan digit of every group into an external chain.
//
//   Channel   Handshake              Payload
//   command   start / busy           i_operation, i_group, i_value
//   result    o_strobe               o_serial_bit, o_last, o_digit_on
//   config    i_cfg_we               i_cfg_idx, i_cfg_data
//
// A refresh tick first reads the first store row, then shifts out the scan
// digit byte of every group, the chain being fed a bit at a time from the
// shift register. A number write waits for the converter, which takes one
// input bit per cycle; an LED word write writes the voltage and battery rows.
// Reset is synchronous; it clears the store through per-group valid bits,
// the scan digit and the control registers. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module seven_segment_scan_shifter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [sss_pkg::OP_W-1:0]         i_operation,
    input  logic [sss_pkg::GROUP_W-1:0]      i_group,
    input  logic [sss_pkg::VALUE_W-1:0]      i_value,
    input  logic                             i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_strobe,
    output logic                             o_serial_bit,
    output logic                             o_last,
    output logic [sss_pkg::DIG_W-1:0]        o_digit_on
);
    import sss_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_BCD    = 4'b0010,
        ST_LED_HI = 4'b0100,
        ST_SHIFT  = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [CFG_DATA_W-1:0]  r_volt_grp;
    logic [CFG_DATA_W-1:0]  r_batt_grp;
    logic [DIG_W-1:0]       r_scan;
    logic [GRP_W-1:0]       r_grp;
    logic [BIT_W-1:0]       r_k;
    logic [GRP_W-1:0]       r_wgrp;
    logic [SEG_W-1:0]       r_hi_byte;
    logic [SEG_W-1:0]       r_shift;
    logic [GROUP_COUNT-1:0] r_valid;
    logic [ROW_W-1:0]       r_mem [GROUP_COUNT];
    logic [ROW_W-1:0]       r_rdata;
    logic                   r_rd_valid;
    logic                   r_strobe;
    logic                   r_serial_bit;
    logic                   r_last;
    logic [DIG_W-1:0]       r_digit_on;

    logic                   accept;
    logic                   bcd_start;
    t_bcd_status            bcd_status;
    logic                   wr_en;
    logic [GRP_W-1:0]       wr_addr;
    logic [ROW_W-1:0]       wr_data;
    logic                   rd_en;
    logic [GRP_W-1:0]       rd_addr;
    logic                   shifting;
    logic                   fin;
    logic [SEG_W-1:0]       cur_byte;
    logic                   grp_ok;
    logic                   volt_ok;
    logic                   batt_ok;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign grp_ok   = (32'(i_group) < GROUP_COUNT);
    assign volt_ok  = (32'(r_volt_grp) < GROUP_COUNT);
    assign batt_ok  = (32'(r_batt_grp) < GROUP_COUNT);
    assign shifting = (r_state == ST_SHIFT);
    assign fin      = shifting && (r_k == BIT_W'(SEG_W - 1))
                      && (r_grp == GRP_W'(GROUP_COUNT - 1));

    assign bcd_start = accept && (t_op'(i_operation) == OP_NUMBER) && grp_ok;

    sss_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (bcd_start),
        .i_value  (i_value),
        .o_status (bcd_status)
    );

    // Byte for the bit now going out: a new row byte at the start of a group.
    always_comb begin
        if (r_k == '0) begin
            cur_byte = r_rd_valid ? r_rdata[r_scan*SEG_W +: SEG_W] : '0;
        end else begin
            cur_byte = r_shift;
        end
    end

    // Store write and read ports, and next-state logic.
    always_comb begin
        n_state = r_state;
        wr_en   = 1'b0;
        wr_addr = r_wgrp;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_op'(i_operation))
                        OP_NUMBER: begin
                            if (grp_ok) begin
                                n_state = ST_BCD;
                            end
                        end
                        OP_LED: begin
                            wr_en   = volt_ok;
                            wr_addr = GRP_W'(r_volt_grp);
                            wr_data = {DIGITS_PER_GROUP{i_value[SEG_W-1:0]}};
                            n_state = ST_LED_HI;
                        end
                        OP_TICK: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = ST_SHIFT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BCD: begin
                if (bcd_status.done) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wgrp;
                    for (int d = 0; d < DIGITS_PER_GROUP; d++) begin
                        wr_data[d*SEG_W +: SEG_W] = seg_code(bcd_status.digits[d]);
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_LED_HI: begin
                wr_en   = batt_ok;
                wr_addr = GRP_W'(r_batt_grp);
                wr_data = {DIGITS_PER_GROUP{r_hi_byte}};
                n_state = ST_IDLE;
            end
            ST_SHIFT: begin
                // Prefetch the next group's row while this byte shifts out.
                if (r_k == '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_grp + 1'b1;
                end
                if (fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Segment store: one row per group, registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Control state, valid bits, configuration registers, scan counters and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_scan     <= '0;
            r_grp      <= '0;
            r_k        <= '0;
            r_strobe   <= 1'b0;
            r_volt_grp <= VOLTAGE_LED_RESET;
            r_batt_grp <= BATTERY_LED_RESET;
        end else begin
            r_state  <= n_state;
            r_strobe <= shifting;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_valid <= r_valid[rd_addr];
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_VOLTAGE_LED_GROUP: r_volt_grp <= i_cfg_data;
                    CFG_BATTERY_LED_GROUP: r_batt_grp <= i_cfg_data;
                    default:               r_volt_grp <= r_volt_grp;
                endcase
            end
            if (accept) begin
                r_grp <= '0;
                r_k   <= '0;
            end else if (shifting) begin
                r_k <= r_k + 1'b1;
                if (r_k == BIT_W'(SEG_W - 1)) begin
                    r_grp <= r_grp + 1'b1;
                end
                if (fin) begin
                    r_scan <= r_scan + 1'b1;
                end
            end
        end
    end

    // Payload registers: transaction capture and the output bit stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wgrp    <= GRP_W'(i_group);
            r_hi_byte <= i_value[VALUE_W-1:SEG_W];
        end
        if (shifting) begin
            r_shift      <= {cur_byte[SEG_W-2:0], 1'b0};
            r_serial_bit <= cur_byte[SEG_W-1];
            r_last       <= fin;
            r_digit_on   <= fin ? r_scan : '0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_serial_bit = r_serial_bit;
    assign o_last       = r_last;
    assign o_digit_on   = r_digit_on;

endmodule
